@@ rtl/arv_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants, register codes and pipeline item type for the arrive steering core.
package arv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LANES     = 3;
	localparam int IN_W      = 32;
	localparam int CFG_W     = 31;

	localparam int DW     = IN_W + 1;
	localparam int SW     = 2 * DW;
	localparam int DIST_W = DW;
	localparam int SPD_W  = CFG_W;
	localparam int PM_W   = CFG_W + DIST_W;
	localparam int PB_W   = DW + SPD_W;
	localparam int ERR_W  = IN_W + 2;
	localparam int EM_W   = IN_W;
	localparam int A_W    = EM_W + FRAC_BITS;
	localparam int AL_W   = A_W / 2;
	localparam int AH_W   = A_W - AL_W;
	localparam int SQA_W  = 2 * A_W;
	localparam int SA_W   = SQA_W + 2;
	localparam int MA2_W  = 2 * CFG_W;
	localparam int PH_W   = AH_W + CFG_W;
	localparam int PL_W   = AL_W + CFG_W;
	localparam int NUMD_W = A_W + CFG_W;

	localparam int RTW = SA_W / 2;
	localparam int RMW = RTW + 2;
	localparam int DVW = RTW;
	localparam int QW  = A_W;

	localparam int N_SQ1    = SW / 2;
	localparam int N_DA     = SPD_W;
	localparam int N_DB     = SPD_W;
	localparam int N_DC     = A_W;
	localparam int N_SQ2    = RTW;
	localparam int N_DD     = SPD_W;
	localparam int N_STAGES = 12;
	localparam int LAT      = N_STAGES + N_SQ1 + N_DA + N_DB + N_DC + N_SQ2 + N_DD;

	localparam logic [CFG_W-1:0] SLOW_RADIUS_RST = CFG_W'(10 << FRAC_BITS);
	localparam logic [CFG_W-1:0] TTT_RST         = CFG_W'(((1 << FRAC_BITS) + 5) / 10);

	typedef enum logic [1:0] {
		REG_MAX_SPEED = 2'd0,
		REG_MAX_ACCEL = 2'd1,
		REG_SLOW_RAD  = 2'd2,
		REG_TTT       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LANES-1:0][DW-1:0]   dm;
		logic [LANES-1:0]           dneg;
		logic [LANES-1:0][IN_W-1:0] vel;
		logic                       zero;
		logic [DIST_W-1:0]          dlen;
		logic                       usemax;
		logic [LANES-1:0]           eneg;
		logic [LANES-1:0][A_W-1:0]  amag;
		logic                       clamp;
	} item_t;

endpackage

@@ rtl/arv_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring divider step: one quotient bit per cell, registered.
module arv_div_cell (
	input  logic                     clk,
	input  logic [arv_pkg::DVW-1:0]  rem,
	input  logic [arv_pkg::QW-1:0]   nq,
	input  logic [arv_pkg::DVW-1:0]  dvs,
	output logic [arv_pkg::DVW-1:0]  rem_nx,
	output logic [arv_pkg::QW-1:0]   nq_nx,
	output logic [arv_pkg::DVW-1:0]  dvs_nx
);

	logic [arv_pkg::DVW:0]   trial;
	logic [arv_pkg::DVW:0]   diff;
	logic                    ge;
	logic [arv_pkg::DVW-1:0] rem_q;
	logic [arv_pkg::QW-1:0]  nq_q;
	logic [arv_pkg::DVW-1:0] dvs_q;

	assign trial = {rem, nq[arv_pkg::QW-1]};
	assign ge    = trial >= {1'b0, dvs};
	assign diff  = trial - {1'b0, dvs};

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[arv_pkg::DVW-1:0] : trial[arv_pkg::DVW-1:0];
		nq_q  <= {nq[arv_pkg::QW-2:0], ge};
		dvs_q <= dvs;
	end

	assign rem_nx = rem_q;
	assign nq_nx  = nq_q;
	assign dvs_nx = dvs_q;

endmodule

@@ rtl/arv_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One digit-by-digit square root step: one root bit per cell, registered.
module arv_sqrt_cell (
	input  logic                       clk,
	input  logic [arv_pkg::RMW-1:0]    rem,
	input  logic [arv_pkg::RTW-1:0]    root,
	input  logic [2*arv_pkg::RTW-1:0]  rad,
	output logic [arv_pkg::RMW-1:0]    rem_nx,
	output logic [arv_pkg::RTW-1:0]    root_nx,
	output logic [2*arv_pkg::RTW-1:0]  rad_nx
);

	logic [arv_pkg::RMW+1:0]   acc;
	logic [arv_pkg::RMW+1:0]   trial;
	logic [arv_pkg::RMW+1:0]   diff;
	logic                      ge;
	logic [arv_pkg::RMW-1:0]   rem_q;
	logic [arv_pkg::RTW-1:0]   root_q;
	logic [2*arv_pkg::RTW-1:0] rad_q;

	assign acc   = {rem, rad[2*arv_pkg::RTW-1 -: 2]};
	assign trial = (arv_pkg::RMW + 2)'({root, 2'b01});
	assign ge    = acc >= trial;
	assign diff  = acc - trial;

	always_ff @(posedge clk) begin
		rem_q  <= ge ? diff[arv_pkg::RMW-1:0] : acc[arv_pkg::RMW-1:0];
		root_q <= {root[arv_pkg::RTW-2:0], ge};
		rad_q  <= {rad[2*arv_pkg::RTW-3:0], 2'b00};
	end

	assign rem_nx  = rem_q;
	assign root_nx = root_q;
	assign rad_nx  = rad_q;

endmodule

@@ rtl/arrive_steering_core.sv @@
`timescale 1ns / 1ps
// Top level: arrive steering acceleration pipeline for one agent word per cycle.
//
// Input: a word (target, position, velocity, signed Q16.16) is taken on every
// cycle with start high; busy is always low, so a word may follow every cycle.
// Config: cfg_index/cfg_data written when cfg_valid is high (cfg_ready is
// always high). 0 max_speed, 1 max_accel, 2 slow_radius, 3 time_to_target;
// the low 31 bits of cfg_data are kept. Write only while no word is in flight.
// Output: accel_x/y/z and was_clamped are valid for the single cycle in which
// done is high; the receiver must take them then, there is no back pressure.
// Throughput: one word per cycle. The depth of the pipeline is set by the bit-serial
// cell rows: two square roots (33 and 49 cells) and four divider rows (31, 31, 48 and
// 31 cells, the last three repeated per lane), plus 12 stages.
// Reset clears the in-flight valid line and loads register defaults
// (max_speed 0, max_accel 0, slow_radius 10.0, time_to_target 0.1); words in
// flight at reset are dropped.
module arrive_steering_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] target_x,
	input  logic [31:0] target_y,
	input  logic [31:0] target_z,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [31:0] accel_x,
	output logic [31:0] accel_y,
	output logic [31:0] accel_z,
	output logic        was_clamped
);

	localparam int LANES  = arv_pkg::LANES;
	localparam int IN_W   = arv_pkg::IN_W;
	localparam int CFG_W  = arv_pkg::CFG_W;
	localparam int DW     = arv_pkg::DW;
	localparam int SW     = arv_pkg::SW;
	localparam int DIST_W = arv_pkg::DIST_W;
	localparam int SPD_W  = arv_pkg::SPD_W;
	localparam int PM_W   = arv_pkg::PM_W;
	localparam int PB_W   = arv_pkg::PB_W;
	localparam int ERR_W  = arv_pkg::ERR_W;
	localparam int EM_W   = arv_pkg::EM_W;
	localparam int A_W    = arv_pkg::A_W;
	localparam int AL_W   = arv_pkg::AL_W;
	localparam int AH_W   = arv_pkg::AH_W;
	localparam int SQA_W  = arv_pkg::SQA_W;
	localparam int SA_W   = arv_pkg::SA_W;
	localparam int MA2_W  = arv_pkg::MA2_W;
	localparam int PH_W   = arv_pkg::PH_W;
	localparam int PL_W   = arv_pkg::PL_W;
	localparam int NUMD_W = arv_pkg::NUMD_W;
	localparam int RTW    = arv_pkg::RTW;
	localparam int RMW    = arv_pkg::RMW;
	localparam int DVW    = arv_pkg::DVW;
	localparam int QW     = arv_pkg::QW;
	localparam int N_SQ1  = arv_pkg::N_SQ1;
	localparam int N_DA   = arv_pkg::N_DA;
	localparam int N_DB   = arv_pkg::N_DB;
	localparam int N_DC   = arv_pkg::N_DC;
	localparam int N_SQ2  = arv_pkg::N_SQ2;
	localparam int N_DD   = arv_pkg::N_DD;
	localparam int LAT    = arv_pkg::LAT;

	localparam logic [A_W-1:0]  POS_LIM = A_W'(32'h7FFF_FFFF);
	localparam logic [A_W-1:0]  NEG_LIM = A_W'(32'h8000_0000);
	localparam logic [IN_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [IN_W-1:0] SAT_MIN = 32'h8000_0000;

	function automatic logic [IN_W:0] abs_w(input logic [IN_W-1:0] v);
		logic [IN_W:0] x;
		x = {v[IN_W-1], v};
		return v[IN_W-1] ? -x : x;
	endfunction

	// config registers
	logic [CFG_W-1:0] ms_q, ma_q, sr_q, ttt_q;
	logic [CFG_W-1:0] ttt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q  <= '0;
			ma_q  <= '0;
			sr_q  <= arv_pkg::SLOW_RADIUS_RST;
			ttt_q <= arv_pkg::TTT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (arv_pkg::cfg_reg_t'(cfg_index))
				arv_pkg::REG_MAX_SPEED: ms_q  <= cfg_data[CFG_W-1:0];
				arv_pkg::REG_MAX_ACCEL: ma_q  <= cfg_data[CFG_W-1:0];
				arv_pkg::REG_SLOW_RAD:  sr_q  <= cfg_data[CFG_W-1:0];
				arv_pkg::REG_TTT:       ttt_q <= cfg_data[CFG_W-1:0];
				default:                ms_q  <= ms_q;
			endcase
		end
	end

	assign ttt_eff   = (ttt_q == '0) ? CFG_W'(1) : ttt_q;
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// valid line
	logic [LAT-1:0] vld_q;
	logic           accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	logic [IN_W-1:0] tgt [LANES];
	logic [IN_W-1:0] pos [LANES];
	logic [IN_W-1:0] vin [LANES];

	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;
	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;
	assign vin[0] = vel_x;
	assign vin[1] = vel_y;
	assign vin[2] = vel_z;

	// s1: differences
	logic [DW-1:0]   d_s1   [LANES];
	logic [IN_W-1:0] vel_s1 [LANES];

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			d_s1[i]   <= {tgt[i][IN_W-1], tgt[i]} - {pos[i][IN_W-1], pos[i]};
			vel_s1[i] <= vin[i];
		end
	end

	// s2: magnitudes and squares
	arv_pkg::item_t it_s2, it2_nx;
	logic [SW-1:0]  sq_s2 [LANES];
	logic [DW-1:0]  dm2   [LANES];

	always_comb begin
		it2_nx = '0;
		for (int i = 0; i < LANES; i++) begin
			dm2[i]         = d_s1[i][DW-1] ? -d_s1[i] : d_s1[i];
			it2_nx.dm[i]   = dm2[i];
			it2_nx.dneg[i] = d_s1[i][DW-1];
			it2_nx.vel[i]  = vel_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		it_s2 <= it2_nx;
		for (int i = 0; i < LANES; i++) begin
			sq_s2[i] <= dm2[i] * dm2[i];
		end
	end

	// s3: sum of squares
	arv_pkg::item_t it_s3, it3_nx;
	logic [SW-1:0]  s_s3, s3_nx;

	always_comb begin
		s3_nx       = sq_s2[0] + sq_s2[1] + sq_s2[2];
		it3_nx      = it_s2;
		it3_nx.zero = (s3_nx == '0);
	end

	always_ff @(posedge clk) begin
		it_s3 <= it3_nx;
		s_s3  <= s3_nx;
	end

	// distance root row
	logic [RMW-1:0]   q1_rem  [N_SQ1+1];
	logic [RTW-1:0]   q1_root [N_SQ1+1];
	logic [2*RTW-1:0] q1_rad  [N_SQ1+1];
	arv_pkg::item_t   sb_sq1_q [N_SQ1];

	assign q1_rem[0]  = '0;
	assign q1_root[0] = '0;
	assign q1_rad[0]  = {s_s3, (2*RTW-SW)'(0)};

	for (genvar k = 0; k < N_SQ1; k++) begin : g_sq1
		arv_sqrt_cell u_cell (
			.clk     (clk),
			.rem     (q1_rem[k]),
			.root    (q1_root[k]),
			.rad     (q1_rad[k]),
			.rem_nx  (q1_rem[k+1]),
			.root_nx (q1_root[k+1]),
			.rad_nx  (q1_rad[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sb_sq1_q[0] <= it_s3;
		for (int k = 1; k < N_SQ1; k++) sb_sq1_q[k] <= sb_sq1_q[k-1];
	end

	// s4: speed numerator
	arv_pkg::item_t    it_s4, it4_nx;
	logic [PM_W-1:0]   pm_s4;
	logic [DIST_W-1:0] dist4;

	always_comb begin
		dist4         = q1_root[N_SQ1][DIST_W-1:0];
		it4_nx        = sb_sq1_q[N_SQ1-1];
		it4_nx.dlen   = dist4;
		it4_nx.usemax = dist4 > DIST_W'(sr_q);
	end

	always_ff @(posedge clk) begin
		it_s4 <= it4_nx;
		pm_s4 <= ms_q * dist4;
	end

	// speed divider row
	logic [DVW-1:0] da_rem [N_DA+1];
	logic [QW-1:0]  da_nq  [N_DA+1];
	logic [DVW-1:0] da_dvs [N_DA+1];
	arv_pkg::item_t sb_da_q [N_DA];

	assign da_rem[0] = DVW'(pm_s4[PM_W-1:SPD_W]);
	assign da_nq[0]  = QW'(pm_s4[SPD_W-1:0]) << (QW - SPD_W);
	assign da_dvs[0] = DVW'(sr_q);

	for (genvar k = 0; k < N_DA; k++) begin : g_da
		arv_div_cell u_cell (
			.clk    (clk),
			.rem    (da_rem[k]),
			.nq     (da_nq[k]),
			.dvs    (da_dvs[k]),
			.rem_nx (da_rem[k+1]),
			.nq_nx  (da_nq[k+1]),
			.dvs_nx (da_dvs[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sb_da_q[0] <= it_s4;
		for (int k = 1; k < N_DA; k++) sb_da_q[k] <= sb_da_q[k-1];
	end

	// s5: desired velocity numerators
	arv_pkg::item_t   it_s5;
	logic [PB_W-1:0]  prod_s5 [LANES];
	logic [SPD_W-1:0] speed5;

	assign speed5 = sb_da_q[N_DA-1].usemax ? ms_q : da_nq[N_DA][SPD_W-1:0];

	always_ff @(posedge clk) begin
		it_s5 <= sb_da_q[N_DA-1];
		for (int i = 0; i < LANES; i++) begin
			prod_s5[i] <= sb_da_q[N_DA-1].dm[i] * speed5;
		end
	end

	// desired velocity divider rows
	logic [DVW-1:0] db_rem [LANES][N_DB+1];
	logic [QW-1:0]  db_nq  [LANES][N_DB+1];
	logic [DVW-1:0] db_dvs [LANES][N_DB+1];
	arv_pkg::item_t sb_db_q [N_DB];

	for (genvar i = 0; i < LANES; i++) begin : g_db_lane
		assign db_rem[i][0] = DVW'(prod_s5[i][PB_W-1:SPD_W]);
		assign db_nq[i][0]  = QW'(prod_s5[i][SPD_W-1:0]) << (QW - SPD_W);
		assign db_dvs[i][0] = DVW'(it_s5.dlen);
		for (genvar k = 0; k < N_DB; k++) begin : g_db
			arv_div_cell u_cell (
				.clk    (clk),
				.rem    (db_rem[i][k]),
				.nq     (db_nq[i][k]),
				.dvs    (db_dvs[i][k]),
				.rem_nx (db_rem[i][k+1]),
				.nq_nx  (db_nq[i][k+1]),
				.dvs_nx (db_dvs[i][k+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		sb_db_q[0] <= it_s5;
		for (int k = 1; k < N_DB; k++) sb_db_q[k] <= sb_db_q[k-1];
	end

	// s6: velocity error
	arv_pkg::item_t  it_s6, it6_nx;
	logic [EM_W-1:0] emag_s6 [LANES];
	logic [EM_W-1:0] emag6   [LANES];
	logic [ERR_W-1:0] sw6    [LANES];
	logic [ERR_W-1:0] err6   [LANES];
	logic [ERR_W-1:0] eabs6  [LANES];

	always_comb begin
		it6_nx = sb_db_q[N_DB-1];
		for (int i = 0; i < LANES; i++) begin
			sw6[i] = ERR_W'(db_nq[i][N_DB][SPD_W-1:0]);
			if (it6_nx.dneg[i]) sw6[i] = -sw6[i];
			err6[i] = sw6[i] - {{(ERR_W-IN_W){it6_nx.vel[i][IN_W-1]}}, it6_nx.vel[i]};
			it6_nx.eneg[i] = err6[i][ERR_W-1];
			eabs6[i] = err6[i][ERR_W-1] ? -err6[i] : err6[i];
			emag6[i] = eabs6[i][EM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		it_s6 <= it6_nx;
		for (int i = 0; i < LANES; i++) emag_s6[i] <= emag6[i];
	end

	// acceleration divider rows
	logic [DVW-1:0] dc_rem [LANES][N_DC+1];
	logic [QW-1:0]  dc_nq  [LANES][N_DC+1];
	logic [DVW-1:0] dc_dvs [LANES][N_DC+1];
	arv_pkg::item_t sb_dc_q [N_DC];

	for (genvar i = 0; i < LANES; i++) begin : g_dc_lane
		assign dc_rem[i][0] = '0;
		assign dc_nq[i][0]  = QW'({emag_s6[i], arv_pkg::FRAC_BITS'(0)});
		assign dc_dvs[i][0] = DVW'(ttt_eff);
		for (genvar k = 0; k < N_DC; k++) begin : g_dc
			arv_div_cell u_cell (
				.clk    (clk),
				.rem    (dc_rem[i][k]),
				.nq     (dc_nq[i][k]),
				.dvs    (dc_dvs[i][k]),
				.rem_nx (dc_rem[i][k+1]),
				.nq_nx  (dc_nq[i][k+1]),
				.dvs_nx (dc_dvs[i][k+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		sb_dc_q[0] <= it_s6;
		for (int k = 1; k < N_DC; k++) sb_dc_q[k] <= sb_dc_q[k-1];
	end

	// s7: partial products of squares
	arv_pkg::item_t     it_s7, it7_nx;
	logic [2*AH_W-1:0]  hh_s7 [LANES];
	logic [AH_W+AL_W-1:0] hl_s7 [LANES];
	logic [2*AL_W-1:0]  ll_s7 [LANES];
	logic [MA2_W-1:0]   ma2_s7;

	always_comb begin
		it7_nx = sb_dc_q[N_DC-1];
		for (int i = 0; i < LANES; i++) it7_nx.amag[i] = dc_nq[i][N_DC][A_W-1:0];
	end

	always_ff @(posedge clk) begin
		it_s7  <= it7_nx;
		ma2_s7 <= ma_q * ma_q;
		for (int i = 0; i < LANES; i++) begin
			hh_s7[i] <= it7_nx.amag[i][A_W-1:AL_W] * it7_nx.amag[i][A_W-1:AL_W];
			hl_s7[i] <= it7_nx.amag[i][A_W-1:AL_W] * it7_nx.amag[i][AL_W-1:0];
			ll_s7[i] <= it7_nx.amag[i][AL_W-1:0] * it7_nx.amag[i][AL_W-1:0];
		end
	end

	// s8: lane squares
	arv_pkg::item_t   it_s8;
	logic [SQA_W-1:0] sqa_s8 [LANES];
	logic [MA2_W-1:0] ma2_s8;

	always_ff @(posedge clk) begin
		it_s8  <= it_s7;
		ma2_s8 <= ma2_s7;
		for (int i = 0; i < LANES; i++) begin
			sqa_s8[i] <= (SQA_W'(hh_s7[i]) << (2*AL_W))
			           + (SQA_W'(hl_s7[i]) << (AL_W + 1))
			           + SQA_W'(ll_s7[i]);
		end
	end

	// s9: squared magnitude and limit compare
	arv_pkg::item_t it_s9, it9_nx;
	logic [SA_W-1:0] sa_s9, sa9;

	always_comb begin
		sa9          = SA_W'(sqa_s8[0]) + SA_W'(sqa_s8[1]) + SA_W'(sqa_s8[2]);
		it9_nx       = it_s8;
		it9_nx.clamp = sa9 > SA_W'(ma2_s8);
	end

	always_ff @(posedge clk) begin
		it_s9 <= it9_nx;
		sa_s9 <= sa9;
	end

	// magnitude root row
	logic [RMW-1:0]   q2_rem  [N_SQ2+1];
	logic [RTW-1:0]   q2_root [N_SQ2+1];
	logic [2*RTW-1:0] q2_rad  [N_SQ2+1];
	arv_pkg::item_t   sb_sq2_q [N_SQ2];

	assign q2_rem[0]  = '0;
	assign q2_root[0] = '0;
	assign q2_rad[0]  = (2*RTW)'(sa_s9);

	for (genvar k = 0; k < N_SQ2; k++) begin : g_sq2
		arv_sqrt_cell u_cell (
			.clk     (clk),
			.rem     (q2_rem[k]),
			.root    (q2_root[k]),
			.rad     (q2_rad[k]),
			.rem_nx  (q2_rem[k+1]),
			.root_nx (q2_root[k+1]),
			.rad_nx  (q2_rad[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sb_sq2_q[0] <= it_s9;
		for (int k = 1; k < N_SQ2; k++) sb_sq2_q[k] <= sb_sq2_q[k-1];
	end

	// s10: rescale partial products
	arv_pkg::item_t  it_s10;
	logic [RTW-1:0]  m_s10;
	logic [PH_W-1:0] ph_s10 [LANES];
	logic [PL_W-1:0] pl_s10 [LANES];

	always_ff @(posedge clk) begin
		it_s10 <= sb_sq2_q[N_SQ2-1];
		m_s10  <= q2_root[N_SQ2];
		for (int i = 0; i < LANES; i++) begin
			ph_s10[i] <= sb_sq2_q[N_SQ2-1].amag[i][A_W-1:AL_W] * ma_q;
			pl_s10[i] <= sb_sq2_q[N_SQ2-1].amag[i][AL_W-1:0] * ma_q;
		end
	end

	// s11: rescale numerator
	arv_pkg::item_t    it_s11;
	logic [RTW-1:0]    m_s11;
	logic [NUMD_W-1:0] num_s11 [LANES];

	always_ff @(posedge clk) begin
		it_s11 <= it_s10;
		m_s11  <= m_s10;
		for (int i = 0; i < LANES; i++) begin
			num_s11[i] <= (NUMD_W'(ph_s10[i]) << AL_W) + NUMD_W'(pl_s10[i]);
		end
	end

	// rescale divider rows
	logic [DVW-1:0] dd_rem [LANES][N_DD+1];
	logic [QW-1:0]  dd_nq  [LANES][N_DD+1];
	logic [DVW-1:0] dd_dvs [LANES][N_DD+1];
	arv_pkg::item_t sb_dd_q [N_DD];

	for (genvar i = 0; i < LANES; i++) begin : g_dd_lane
		assign dd_rem[i][0] = DVW'(num_s11[i][NUMD_W-1:SPD_W]);
		assign dd_nq[i][0]  = QW'(num_s11[i][SPD_W-1:0]) << (QW - SPD_W);
		assign dd_dvs[i][0] = DVW'(m_s11);
		for (genvar k = 0; k < N_DD; k++) begin : g_dd
			arv_div_cell u_cell (
				.clk    (clk),
				.rem    (dd_rem[i][k]),
				.nq     (dd_nq[i][k]),
				.dvs    (dd_dvs[i][k]),
				.rem_nx (dd_rem[i][k+1]),
				.nq_nx  (dd_nq[i][k+1]),
				.dvs_nx (dd_dvs[i][k+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		sb_dd_q[0] <= it_s11;
		for (int k = 1; k < N_DD; k++) sb_dd_q[k] <= sb_dd_q[k-1];
	end

	// s12: sign, saturate, output register
	arv_pkg::item_t  it12;
	logic [IN_W-1:0] acc12 [LANES];
	logic [IN_W-1:0] q12   [LANES];
	logic [IN_W-1:0] acc_s12 [LANES];
	logic            clamp_s12;

	assign it12 = sb_dd_q[N_DD-1];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			q12[i] = IN_W'(dd_nq[i][N_DD][SPD_W-1:0]);
			if (it12.zero) begin
				acc12[i] = '0;
			end else if (it12.clamp) begin
				acc12[i] = it12.eneg[i] ? -q12[i] : q12[i];
			end else if (!it12.eneg[i]) begin
				acc12[i] = (it12.amag[i] > POS_LIM) ? SAT_MAX : it12.amag[i][IN_W-1:0];
			end else begin
				acc12[i] = (it12.amag[i] >= NEG_LIM) ? SAT_MIN : -it12.amag[i][IN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		clamp_s12 <= it12.clamp && !it12.zero;
		for (int i = 0; i < LANES; i++) acc_s12[i] <= acc12[i];
	end

	assign done        = vld_q[LAT-1];
	assign accel_x     = acc_s12[0];
	assign accel_y     = acc_s12[1];
	assign accel_z     = acc_s12[2];
	assign was_clamped = clamp_s12;

	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without matching accepted word");

	a_clamp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_clamped |-> (abs_w(accel_x) <= (IN_W + 1)'(ma_q))
			&& (abs_w(accel_y) <= (IN_W + 1)'(ma_q))
			&& (abs_w(accel_z) <= (IN_W + 1)'(ma_q)))
		else $error("rescaled acceleration exceeds max_accel");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start) |-> !busy && cfg_ready)
		else $error("core stalled input or config channel");

endmodule

@@ sim/arrive_steering_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for arrive_steering_core: random and directed agent words checked against a predictor.
module arrive_steering_core_tb;

	typedef logic [127:0] u128_t;

	typedef struct {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic        clamp;
	} accel_t;

	class accel_board;
		accel_t      pending[$];
		int          errors;
		int          clamps;
		int          words;
		logic [30:0] max_speed;
		logic [30:0] max_accel;
		logic [30:0] slow_radius;
		logic [30:0] ttt;

		function new();
			errors      = 0;
			clamps      = 0;
			words       = 0;
			max_speed   = '0;
			max_accel   = '0;
			slow_radius = arv_pkg::SLOW_RADIUS_RST;
			ttt         = arv_pkg::TTT_RST;
		endfunction

		function automatic logic [63:0] isqrt(u128_t s);
			logic [63:0] r;
			logic [63:0] c;
			r = '0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (u128_t'(c) * u128_t'(c) <= s)
					r = c;
			end
			return r;
		endfunction

		function automatic logic [31:0] sat(u128_t m, bit neg);
			if (!neg)
				return (m > 128'h7fffffff) ? 32'h7fffffff : m[31:0];
			return (m > 128'h80000000) ? 32'h80000000 : 32'(-m[31:0]);
		endfunction

		function automatic accel_t steer(logic [31:0] w[9]);
			accel_t r;
			u128_t  s, sa, span, speed, rate, want, m;
			u128_t  dm[3];
			u128_t  am[3];
			bit     dn[3];
			bit     an[3];
			longint dd, ws, er;
			s  = '0;
			sa = '0;
			for (int i = 0; i < 3; i++) begin
				dd = longint'(signed'(w[i])) - longint'(signed'(w[3+i]));
				dn[i] = dd < 0;
				dm[i] = u128_t'(dn[i] ? -dd : dd);
				s += dm[i] * dm[i];
			end
			r = '{32'd0, 32'd0, 32'd0, 1'b0};
			if (s == 0)
				return r;
			span = u128_t'(isqrt(s));
			if (span > u128_t'(slow_radius))
				speed = u128_t'(max_speed);
			else
				speed = (u128_t'(max_speed) * span) / u128_t'(slow_radius);
			rate = (ttt == 0) ? 128'd1 : u128_t'(ttt);
			for (int i = 0; i < 3; i++) begin
				want = dm[i] * speed / span;
				ws = dn[i] ? -longint'(want) : longint'(want);
				er = ws - longint'(signed'(w[6+i]));
				an[i] = er < 0;
				am[i] = (u128_t'(an[i] ? -er : er) << arv_pkg::FRAC_BITS) / rate;
				sa += am[i] * am[i];
			end
			if (sa > u128_t'(max_accel) * u128_t'(max_accel)) begin
				m = u128_t'(isqrt(sa));
				r.clamp = 1'b1;
				for (int i = 0; i < 3; i++)
					am[i] = am[i] * u128_t'(max_accel) / m;
			end
			r.ax = sat(am[0], an[0]);
			r.ay = sat(am[1], an[1]);
			r.az = sat(am[2], an[2]);
			return r;
		endfunction

		function void note_word(logic [31:0] w[9]);
			pending.push_back(steer(w));
			words++;
		endfunction

		function void check_result(accel_t got);
			accel_t want;
			if (pending.size() == 0) begin
				$error("result with no word outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.ax !== want.ax) begin
				$error("accel_x expected %h got %h", want.ax, got.ax);
				errors++;
			end
			if (got.ay !== want.ay) begin
				$error("accel_y expected %h got %h", want.ay, got.ay);
				errors++;
			end
			if (got.az !== want.az) begin
				$error("accel_z expected %h got %h", want.az, got.az);
				errors++;
			end
			if (got.clamp !== want.clamp) begin
				$error("was_clamped expected %b got %b", want.clamp, got.clamp);
				errors++;
			end
			if (want.clamp)
				clamps++;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [31:0]       word_in[9];
	logic              cfg_valid;
	logic              cfg_ready;
	arv_pkg::cfg_reg_t cfg_index;
	logic [31:0]       cfg_data;
	logic              done;
	logic [31:0]       accel_x, accel_y, accel_z;
	logic              was_clamped;

	accel_board board;
	int         phases;

	arrive_steering_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.target_x(word_in[0]), .target_y(word_in[1]), .target_z(word_in[2]),
		.pos_x(word_in[3]), .pos_y(word_in[4]), .pos_z(word_in[5]),
		.vel_x(word_in[6]), .vel_y(word_in[7]), .vel_z(word_in[8]),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .accel_x(accel_x), .accel_y(accel_y),
		.accel_z(accel_z), .was_clamped(was_clamped)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_word(word_in);
		if (arst_n && done)
			board.check_result('{accel_x, accel_y, accel_z, was_clamped});
	end

	task automatic send_word(logic [31:0] w[9]);
		word_in = w;
		start   = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
			@(negedge clk);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (arv_pkg::LAT + 10) @(negedge clk);
	endtask

	task automatic write_reg(arv_pkg::cfg_reg_t idx, logic [30:0] val);
		cfg_index = idx;
		cfg_data  = {1'($urandom), val};
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			arv_pkg::REG_MAX_SPEED: board.max_speed   = val;
			arv_pkg::REG_MAX_ACCEL: board.max_accel   = val;
			arv_pkg::REG_SLOW_RAD:  board.slow_radius = val;
			arv_pkg::REG_TTT:       board.ttt         = val;
		endcase
	endtask

	function automatic logic [31:0] coord(int mode);
		case (mode)
			0:       return $urandom;
			1:       return $urandom_range(0, 40 << 16) - (20 << 16);
			default: return $urandom_range(0, 1 << 12) - (1 << 11);
		endcase
	endfunction

	task automatic send_random(int count);
		logic [31:0] w[9];
		int          burst;
		int          pm, vm;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			pm = $urandom_range(0, 5);
			vm = $urandom_range(0, 3);
			for (int i = 0; i < 3; i++) begin
				w[3+i] = coord(pm == 0 ? 0 : 1);
				case (pm)
					0:       w[i] = coord(0);
					1, 2:    w[i] = w[3+i] + coord(1);
					3:       w[i] = w[3+i] + coord(2);
					4:       w[i] = w[3+i];
					default: w[i] = coord(0);
				endcase
				w[6+i] = (vm == 0) ? coord(0) : coord(vm == 1 ? 1 : 2);
			end
			send_word(w);
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0) begin
					start = 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
			end else
				burst--;
		end
		start = 1'b0;
	endtask

	task automatic send_directed();
		logic [31:0] lo, hi;
		lo = 32'h80000000;
		hi = 32'h7fffffff;
		send_word('{hi, hi, hi, lo, lo, lo, lo, lo, lo});
		send_word('{lo, lo, lo, hi, hi, hi, hi, hi, hi});
		send_word('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_word('{5, 5, 5, 5, 5, 5, hi, lo, 7});
		send_word('{1, 0, 0, 0, 0, 0, 0, 0, 0});
		send_word('{0, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0});
		send_word('{10 << 16, 0, 0, 0, 0, 0, 0, 0, 0});
		send_word('{(10 << 16) + 1, 0, 0, 0, 0, 0, 0, 0, 0});
		send_word('{0, 0, 3 << 16, 0, 0, 0, 0, 1 << 16, 0});
		send_word('{hi, 0, 0, lo, 0, 0, 0, 0, 0});
		send_word('{hi, lo, hi, 0, 0, 0, hi, hi, lo});
		send_word('{lo, hi, lo, hi, lo, hi, 32'hffff0000, 1 << 16, 0});
		start = 1'b0;
	endtask

	task automatic run_phase(logic [30:0] ms, logic [30:0] ma, logic [30:0] sr,
		logic [30:0] tt, int count);
		write_reg(arv_pkg::REG_MAX_SPEED, ms);
		write_reg(arv_pkg::REG_MAX_ACCEL, ma);
		write_reg(arv_pkg::REG_SLOW_RAD, sr);
		write_reg(arv_pkg::REG_TTT, tt);
		send_directed();
		send_random(count);
		drain();
		phases++;
	endtask

	initial begin
		board     = new();
		phases    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = arv_pkg::REG_MAX_SPEED;
		cfg_data  = '0;
		foreach (word_in[i])
			word_in[i] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults from reset
		send_directed();
		send_random(150);
		drain();
		run_phase(31'(5 << 16), 31'(20 << 16), 31'(10 << 16), 31'd6554, 300);
		run_phase(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 200);
		run_phase(31'd0, 31'd0, 31'd0, 31'd0, 150);
		run_phase(31'h7fffffff, 31'd1, 31'd1, 31'd1, 200);
		run_phase(31'(3 << 16), 31'h7fffffff, 31'(2 << 16), 31'(1 << 16), 250);
		run_phase(31'($urandom), 31'($urandom), 31'($urandom_range(1, 50 << 16)),
			31'($urandom_range(1, 4 << 16)), 250);

		$display("covered %0d words over %0d register settings, %0d clamped",
			board.words, phases + 1, board.clamps);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ files.f @@
rtl/arv_pkg.sv
rtl/arv_div_cell.sv
rtl/arv_sqrt_cell.sv
rtl/arrive_steering_core.sv
sim/arrive_steering_core_tb.sv
